// ===== rtl/core/rac_pkg.sv =====
`timescale 1ns / 1ps
// Types, constants and arithmetic helpers for the RGBA alpha compositor.
package rac_pkg;

   localparam logic [7:0] FULL = 8'hff;
   localparam int unsigned NUM_CHAN = 3;

   // pipeline depth: four arithmetic stages, three divider stages, output
   localparam int unsigned NUM_STAGES = 8;
   localparam int unsigned NUM_DIV = 3;

   typedef enum logic [1:0] {
      MODE_OVERLAY  = 2'd0,
      MODE_UNDERLAY = 2'd1,
      MODE_BLEND    = 2'd2,
      MODE_DARKEN   = 2'd3
   } mode_type;

   // stage 1: raw products
   typedef struct packed {
      mode_type               mode;
      logic                   pass;
      logic [3:0][7:0]        first;
      logic [2:0][15:0]       p;
      logic [2:0][15:0]       q;
      logic [15:0]            pa;
      logic [7:0]             xa;
      logic [7:0]             ya;
   } s1_type;

   // stage 2: products scaled by 1/255
   typedef struct packed {
      mode_type               mode;
      logic                   pass;
      logic [3:0][7:0]        first;
      logic [2:0][7:0]        px;
      logic [2:0][7:0]        py;
      logic [7:0]             oa;
      logic [7:0]             xa;
   } s2_type;

   // stage 3: bottom color weighted by remaining coverage
   typedef struct packed {
      mode_type               mode;
      logic                   pass;
      logic [3:0][7:0]        first;
      logic [2:0][7:0]        px;
      logic [2:0][15:0]       r;
      logic [7:0]             oa;
   } s3_type;

   // stage 4: composited channels and the undivided result
   typedef struct packed {
      logic [3:0][7:0]        res;
      logic                   dsel;
      logic [2:0][7:0]        c;
      logic [7:0]             oa;
   } s4_type;

   // one lane of the restoring divider
   typedef struct packed {
      logic [7:0]             rem;
      logic [7:0]             low;
      logic [7:0]             quo;
   } div_lane_type;

   // divider stages
   typedef struct packed {
      logic [3:0][7:0]        res;
      logic                   dsel;
      logic [7:0]             d;
      logic [2:0]             sat;
      logic                   zero;
      div_lane_type [2:0]     lane;
   } sd_type;

   // floor(x / 255), exact for x up to 65279
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      return t[15:8];
   endfunction

   // one restoring division step: shift in the next dividend bit
   function automatic div_lane_type div_step(input div_lane_type s, input logic [7:0] d);
      div_lane_type o;
      logic [8:0]   t;
      t = {s.rem, s.low[7]};
      if (t >= {1'b0, d}) begin
         o.rem = 8'(t - {1'b0, d});
         o.quo = {s.quo[6:0], 1'b1};
      end else begin
         o.rem = t[7:0];
         o.quo = {s.quo[6:0], 1'b0};
      end
      o.low = {s.low[6:0], 1'b0};
      return o;
   endfunction

   // two quotient bits per pipeline stage
   function automatic div_lane_type div_step2(input div_lane_type s, input logic [7:0] d);
      return div_step(div_step(s, d), d);
   endfunction

endpackage

// ===== rtl/core/rgba_alpha_compositor.sv =====
`timescale 1ns / 1ps
// Top level of the RGBA alpha compositor: eight-stage pipeline.
//
// Composites two 8-bit RGBA colors in overlay, underlay, blend or darken
// mode, with every scaling an exact truncating division by 255. The block
// takes one transfer per clock unless the result side stalls. The pipeline
// steps are: multiply, scale by 1/255, weight the bottom color, combine, then
// four stages of a restoring divider (two quotient bits per stage) for the
// un-premultiply in blend mode; all modes take the same path so results
// leave in order. Stalls back up stage by stage and empty stages are filled,
// so no transfer is lost or repeated. No state survives an item.
module rgba_alpha_compositor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_first_red,
   input  logic [7:0] req_first_green,
   input  logic [7:0] req_first_blue,
   input  logic [7:0] req_first_alpha,
   input  logic [7:0] req_second_red,
   input  logic [7:0] req_second_green,
   input  logic [7:0] req_second_blue,
   input  logic [7:0] req_second_alpha,
   input  logic [7:0] req_darken_factor,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_red,
   output logic [7:0] rsp_out_green,
   output logic [7:0] rsp_out_blue,
   output logic [7:0] rsp_out_alpha
);
   import rac_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] adv;

   s1_type          s1_ff, s1_in;
   s2_type          s2_ff, s2_in;
   s3_type          s3_ff, s3_in;
   s4_type          s4_ff, s4_in;
   sd_type          sd_ff [NUM_DIV];
   sd_type          sd_in [NUM_DIV];
   logic [3:0][7:0] out_ff, out_in;

   // stage advance: a stage loads when it is empty or its successor moves
   always_comb begin
      adv[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in[0] = req_valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // stage 1: pick top and bottom operands, form the products
   always_comb begin
      mode_type        m;
      logic [2:0][7:0] fc;
      logic [2:0][7:0] sc;
      logic [7:0]      x;
      logic [7:0]      y;
      m  = mode_type'(req_mode);
      fc = {req_first_blue, req_first_green, req_first_red};
      sc = {req_second_blue, req_second_green, req_second_red};
      s1_in.mode  = m;
      s1_in.pass  = (m == MODE_BLEND) && (req_second_alpha == 8'd0);
      s1_in.first = {req_first_alpha, req_first_blue, req_first_green, req_first_red};
      if (m == MODE_DARKEN) begin
         s1_in.xa = req_darken_factor;
      end else if (m == MODE_UNDERLAY) begin
         s1_in.xa = req_first_alpha;
      end else begin
         s1_in.xa = req_second_alpha;
      end
      s1_in.ya = (m == MODE_UNDERLAY) ? req_second_alpha : req_first_alpha;
      for (int c = 0; c < NUM_CHAN; c++) begin
         x = (m == MODE_UNDERLAY || m == MODE_DARKEN) ? fc[c] : sc[c];
         y = (m == MODE_UNDERLAY) ? sc[c] : fc[c];
         s1_in.p[c] = {8'd0, x} * {8'd0, s1_in.xa};
         s1_in.q[c] = {8'd0, y} * {8'd0, s1_in.ya};
      end
      s1_in.pa = {8'd0, s1_in.xa} * {8'd0, FULL - s1_in.ya};
   end

   // stage 2: scale by 1/255, new alpha
   always_comb begin
      s2_in.mode  = s1_ff.mode;
      s2_in.pass  = s1_ff.pass;
      s2_in.first = s1_ff.first;
      s2_in.xa    = s1_ff.xa;
      for (int c = 0; c < NUM_CHAN; c++) begin
         s2_in.px[c] = div255(s1_ff.p[c]);
         s2_in.py[c] = div255(s1_ff.q[c]);
      end
      s2_in.oa = s1_ff.ya + div255(s1_ff.pa);
   end

   // stage 3: weight the bottom color by the top's remaining coverage
   always_comb begin
      s3_in.mode  = s2_ff.mode;
      s3_in.pass  = s2_ff.pass;
      s3_in.first = s2_ff.first;
      s3_in.px    = s2_ff.px;
      s3_in.oa    = s2_ff.oa;
      for (int c = 0; c < NUM_CHAN; c++) begin
         s3_in.r[c] = {8'd0, FULL - s2_ff.xa} * {8'd0, s2_ff.py[c]};
      end
   end

   // stage 4: combine, resolve every mode but the blend divide
   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         s4_in.c[c] = s3_ff.px[c] + div255(s3_ff.r[c]);
      end
      s4_in.oa   = s3_ff.oa;
      s4_in.dsel = (s3_ff.mode == MODE_BLEND) && !s3_ff.pass;
      case (s3_ff.mode)
         MODE_OVERLAY, MODE_UNDERLAY: begin
            s4_in.res = {s3_ff.oa, s4_in.c[2], s4_in.c[1], s4_in.c[0]};
         end
         MODE_BLEND: begin
            s4_in.res = s3_ff.first;
         end
         default: begin
            s4_in.res[3] = s3_ff.first[3];
            for (int c = 0; c < NUM_CHAN; c++) begin
               s4_in.res[c] = s3_ff.first[c] - s3_ff.px[c];
            end
         end
      endcase
   end

   // stages 5 to 7: un-premultiply, c*255/alpha, two quotient bits a stage
   always_comb begin
      logic [15:0]  n;
      div_lane_type init;
      sd_in[0].res  = s4_ff.res;
      sd_in[0].dsel = s4_ff.dsel;
      sd_in[0].d    = s4_ff.oa;
      sd_in[0].zero = (s4_ff.oa == 8'd0);
      for (int c = 0; c < NUM_CHAN; c++) begin
         // quotient reaches 255 exactly when the channel is not below alpha
         sd_in[0].sat[c] = (s4_ff.c[c] >= s4_ff.oa);
         n = {s4_ff.c[c], 8'd0} - {8'd0, s4_ff.c[c]};
         init.rem = n[15:8];
         init.low = n[7:0];
         init.quo = 8'd0;
         sd_in[0].lane[c] = div_step2(init, s4_ff.oa);
      end
      for (int k = 1; k < NUM_DIV; k++) begin
         sd_in[k] = sd_ff[k-1];
         for (int c = 0; c < NUM_CHAN; c++) begin
            sd_in[k].lane[c] = div_step2(sd_ff[k-1].lane[c], sd_ff[k-1].d);
         end
      end
   end

   // stage 8: last quotient bits, saturate, select the result
   always_comb begin
      div_lane_type fin;
      fin    = '0;
      out_in = sd_ff[NUM_DIV-1].res;
      if (sd_ff[NUM_DIV-1].dsel) begin
         out_in[3] = sd_ff[NUM_DIV-1].d;
         for (int c = 0; c < NUM_CHAN; c++) begin
            fin = div_step2(sd_ff[NUM_DIV-1].lane[c], sd_ff[NUM_DIV-1].d);
            if (sd_ff[NUM_DIV-1].zero) begin
               out_in[c] = 8'd0;
            end else if (sd_ff[NUM_DIV-1].sat[c]) begin
               out_in[c] = FULL;
            end else begin
               out_in[c] = fin.quo;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_ff <= s1_in;
      end
      if (adv[1]) begin
         s2_ff <= s2_in;
      end
      if (adv[2]) begin
         s3_ff <= s3_in;
      end
      if (adv[3]) begin
         s4_ff <= s4_in;
      end
      for (int k = 0; k < NUM_DIV; k++) begin
         if (adv[4+k]) begin
            sd_ff[k] <= sd_in[k];
         end
      end
      if (adv[NUM_STAGES-1]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_out_red   = out_ff[0];
   assign rsp_out_green = out_ff[1];
   assign rsp_out_blue  = out_ff[2];
   assign rsp_out_alpha = out_ff[3];

endmodule

// ===== rtl/core/rac_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for the RGBA alpha compositor, bound to the top level.
module rac_chk (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_red,
   input logic [7:0] rsp_out_green,
   input logic [7:0] rsp_out_blue,
   input logic [7:0] rsp_out_alpha
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_red) && $stable(rsp_out_green)
                                  && $stable(rsp_out_blue) && $stable(rsp_out_alpha))
      else $error("result changed while stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // an empty or draining output never blocks the input side
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_ready || !rsp_valid) |-> req_ready)
      else $error("input stalled while output moves");

endmodule

bind rgba_alpha_compositor rac_chk u_rac_chk (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_red   (rsp_out_red),
   .rsp_out_green (rsp_out_green),
   .rsp_out_blue  (rsp_out_blue),
   .rsp_out_alpha (rsp_out_alpha)
);

// ===== test/rac_checker.sv =====
`timescale 1ns / 1ps
// Checker for the RGBA alpha compositor: predicts each result and compares it.
module rac_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_first_red,
   input  logic [7:0] req_first_green,
   input  logic [7:0] req_first_blue,
   input  logic [7:0] req_first_alpha,
   input  logic [7:0] req_second_red,
   input  logic [7:0] req_second_green,
   input  logic [7:0] req_second_blue,
   input  logic [7:0] req_second_alpha,
   input  logic [7:0] req_darken_factor,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_red,
   input  logic [7:0] rsp_out_green,
   input  logic [7:0] rsp_out_blue,
   input  logic [7:0] rsp_out_alpha,
   output int         fail_count,
   output int         pending_count
);
   import rac_pkg::*;

   localparam int unsigned LEVELS = FULL;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } rgba_type;

   // predicted colors, oldest first
   rgba_type expected_colors[$];

   const string field_names[4] = '{"out_red", "out_green", "out_blue", "out_alpha"};

   // one channel of "top over bottom", both weighted by their alphas
   function automatic logic [7:0] over_channel(input int unsigned top, input int unsigned top_a,
                                              input int unsigned bottom,
                                              input int unsigned bottom_a);
      int unsigned top_part, bottom_part;
      top_part = top * top_a / LEVELS;
      bottom_part = bottom * bottom_a / LEVELS;
      return 8'(top_part + (LEVELS - top_a) * bottom_part / LEVELS);
   endfunction

   // divide a premultiplied channel by alpha, clamped at full scale
   function automatic logic [7:0] unpremultiply(input int unsigned chan, input int unsigned alpha);
      int unsigned quot;
      if (alpha == 0) return 8'd0;
      quot = chan * LEVELS / alpha;
      return (quot > LEVELS) ? FULL : 8'(quot);
   endfunction

   function automatic logic [7:0] combined_alpha(input int unsigned top_a,
                                                input int unsigned bottom_a);
      return 8'(bottom_a + top_a * (LEVELS - bottom_a) / LEVELS);
   endfunction

   function automatic logic [7:0] darken_channel(input int unsigned chan, input int unsigned f);
      return 8'(chan - chan * f / LEVELS);
   endfunction

   function automatic rgba_type composite(input mode_type mode, input rgba_type first,
                                          input rgba_type second, input logic [7:0] factor);
      rgba_type res;
      res = first;
      case (mode)
         MODE_OVERLAY: begin
            res.red   = over_channel(second.red, second.alpha, first.red, first.alpha);
            res.green = over_channel(second.green, second.alpha, first.green, first.alpha);
            res.blue  = over_channel(second.blue, second.alpha, first.blue, first.alpha);
            res.alpha = combined_alpha(second.alpha, first.alpha);
         end
         MODE_UNDERLAY: begin
            res.red   = over_channel(first.red, first.alpha, second.red, second.alpha);
            res.green = over_channel(first.green, first.alpha, second.green, second.alpha);
            res.blue  = over_channel(first.blue, first.alpha, second.blue, second.alpha);
            res.alpha = combined_alpha(first.alpha, second.alpha);
         end
         MODE_BLEND: begin
            // transparent second color leaves the first untouched
            if (second.alpha != 0) begin
               res.alpha = combined_alpha(second.alpha, first.alpha);
               res.red   = unpremultiply(over_channel(second.red, second.alpha,
                                                      first.red, first.alpha), res.alpha);
               res.green = unpremultiply(over_channel(second.green, second.alpha,
                                                      first.green, first.alpha), res.alpha);
               res.blue  = unpremultiply(over_channel(second.blue, second.alpha,
                                                      first.blue, first.alpha), res.alpha);
            end
         end
         default: begin
            res.red   = darken_channel(first.red, factor);
            res.green = darken_channel(first.green, factor);
            res.blue  = darken_channel(first.blue, factor);
         end
      endcase
      return res;
   endfunction

   // check result transfers against the queue, then queue new predictions
   always @(posedge clock) begin : watch
      rgba_type want;
      logic [7:0] got[4];
      logic [7:0] exp_field[4];
      if (reset) begin
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_colors.size() == 0) begin
               $error("result transfer with no prediction pending");
               fail_count++;
            end else begin
               want = expected_colors.pop_front();
               got = '{rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha};
               exp_field = '{want.red, want.green, want.blue, want.alpha};
               for (int i = 0; i < 4; i++) begin
                  if (got[i] !== exp_field[i]) begin
                     $error("%s: expected %0d, actual %0d", field_names[i], exp_field[i], got[i]);
                     fail_count++;
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_colors.push_back(composite(mode_type'(req_mode),
               '{req_first_red, req_first_green, req_first_blue, req_first_alpha},
               '{req_second_red, req_second_green, req_second_blue, req_second_alpha},
               req_darken_factor));
         end
      end
      pending_count = expected_colors.size();
   end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the RGBA alpha compositor: stimulus, flow control and verdict.
module tb_top;
   import rac_pkg::*;

   localparam int RANDOM_PIXELS = 800;
   localparam int MAX_IDLE = 14;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_mode = MODE_OVERLAY;
   logic [7:0] req_first_red = '0;
   logic [7:0] req_first_green = '0;
   logic [7:0] req_first_blue = '0;
   logic [7:0] req_first_alpha = '0;
   logic [7:0] req_second_red = '0;
   logic [7:0] req_second_green = '0;
   logic [7:0] req_second_blue = '0;
   logic [7:0] req_second_alpha = '0;
   logic [7:0] req_darken_factor = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_red;
   logic [7:0] rsp_out_green;
   logic [7:0] rsp_out_blue;
   logic [7:0] rsp_out_alpha;
   int         fail_count;
   int         pending_count;

   // back-to-back stretches on each side
   bit send_steady = 1'b0;
   bit drain_steady = 1'b0;

   always #4 clock = ~clock;

   rgba_alpha_compositor DUT (.*);

   rac_checker checker_inst (.*);

   // levels biased toward the extremes
   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return FULL;
         2: return 8'($urandom_range(0, 1));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // present one color pair and hold it until the transfer
   task automatic send_pixel(input mode_type mode, input logic [7:0] fr, input logic [7:0] fg,
                             input logic [7:0] fb, input logic [7:0] fa,
                             input logic [7:0] sr, input logic [7:0] sg,
                             input logic [7:0] sb, input logic [7:0] sa,
                             input logic [7:0] factor);
      int gap;
      if ($urandom_range(0, 39) == 0) send_steady = ~send_steady;
      gap = send_steady ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_mode          <= mode;
      req_first_red     <= fr;
      req_first_green   <= fg;
      req_first_blue    <= fb;
      req_first_alpha   <= fa;
      req_second_red    <= sr;
      req_second_green  <= sg;
      req_second_blue   <= sb;
      req_second_alpha  <= sa;
      req_darken_factor <= factor;
      req_valid         <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // result side: random stalls per transfer
   initial begin : drain
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) drain_steady = ~drain_steady;
         gap = drain_steady ? 0 : $urandom_range(0, MAX_IDLE);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes of every mode
      send_pixel(MODE_OVERLAY, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_pixel(MODE_OVERLAY, 255, 255, 255, 255, 255, 255, 255, 255, 255);
      send_pixel(MODE_OVERLAY, 200, 100, 50, 255, 10, 20, 30, 0, 77);
      send_pixel(MODE_OVERLAY, 200, 100, 50, 0, 10, 20, 30, 255, 0);
      send_pixel(MODE_UNDERLAY, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_pixel(MODE_UNDERLAY, 255, 255, 255, 255, 255, 255, 255, 255, 255);
      send_pixel(MODE_UNDERLAY, 17, 34, 51, 128, 255, 0, 255, 1, 200);
      send_pixel(MODE_UNDERLAY, 255, 0, 170, 1, 85, 255, 0, 254, 3);
      // blend: transparent second color passes the first through
      send_pixel(MODE_BLEND, 12, 34, 56, 78, 255, 255, 255, 0, 255);
      send_pixel(MODE_BLEND, 255, 255, 255, 0, 0, 0, 0, 0, 0);
      send_pixel(MODE_BLEND, 255, 255, 255, 255, 255, 255, 255, 255, 255);
      send_pixel(MODE_BLEND, 255, 255, 255, 1, 255, 255, 255, 1, 0);
      send_pixel(MODE_BLEND, 255, 0, 128, 2, 255, 255, 0, 1, 9);
      send_pixel(MODE_BLEND, 0, 0, 0, 0, 255, 128, 1, 255, 0);
      send_pixel(MODE_BLEND, 254, 3, 99, 3, 250, 2, 1, 2, 0);
      // darken: no effect, full black, partway; second color ignored
      send_pixel(MODE_DARKEN, 255, 255, 255, 255, 1, 2, 3, 4, 0);
      send_pixel(MODE_DARKEN, 255, 255, 255, 255, 255, 255, 255, 255, 255);
      send_pixel(MODE_DARKEN, 255, 128, 1, 7, 0, 0, 0, 0, 128);
      send_pixel(MODE_DARKEN, 0, 0, 0, 0, 255, 255, 255, 255, 1);
      send_pixel(MODE_DARKEN, 254, 1, 200, 0, 9, 9, 9, 9, 254);

      // random color pairs over all modes
      for (int n = 0; n < RANDOM_PIXELS; n++) begin
         send_pixel(mode_type'($urandom_range(0, 3)), pick_level(), pick_level(),
                    pick_level(), pick_level(), pick_level(), pick_level(),
                    pick_level(), pick_level(), pick_level());
      end
      req_valid <= 1'b0;

      // drain, then allow the pipeline depth for any stray result
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS rgba_alpha_compositor");
      end else begin
         $display("FAIL rgba_alpha_compositor");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("FAIL rgba_alpha_compositor");
      $finish;
   end

endmodule
